@@ sv/resonant_four_pole_filter_assert.svh @@
// Assertion macros shared by the filter checker.
`ifndef RESONANT_FOUR_POLE_FILTER_ASSERT_SVH
`define RESONANT_FOUR_POLE_FILTER_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define RFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("filter port assertion failed");

// Next-cycle implication, checked on clk and disabled in reset.
`define RFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("filter port assertion failed");

`endif

@@ sv/rfp_pkg.sv @@
// Shared constants and types of the resonant four-pole filter.
package rfp_pkg;

  localparam int DEF_SAMPLE_WIDTH   = 24;
  localparam int DEF_COEF_FRAC_BITS = 16;

  localparam int CFG_INDEX_W = 8;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_CUTOFF = 8'd0;
  localparam cfg_index_t REG_GAIN   = 8'd1;
  localparam cfg_index_t REG_MODE   = 8'd2;

  typedef enum logic [1:0] {
    MODE_LOWPASS  = 2'd0,
    MODE_HIGHPASS = 2'd1,
    MODE_BANDPASS = 2'd2,
    MODE_MUTE     = 2'd3
  } mode_t;

endpackage

@@ sv/rfp_cfg.sv @@
// Configuration register file: cutoff, feedback gain and output mode.
module rfp_cfg
  import rfp_pkg::*;
#(
  parameter int CW = DEF_COEF_FRAC_BITS,
  parameter int GW = DEF_COEF_FRAC_BITS + 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  cfg_index_t    cfg_index,
  input  logic [GW-1:0] cfg_data,
  output logic [CW-1:0] cutoff,
  output logic [GW-1:0] gain,
  output mode_t         mode
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= '0;
      gain   <= '0;
      mode   <= MODE_LOWPASS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CUTOFF: cutoff <= cfg_data[CW-1:0];
        REG_GAIN:   gain   <= cfg_data;
        REG_MODE:   mode   <= mode_t'(cfg_data[1:0]);
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

endmodule

@@ sv/rfp_mul.sv @@
// Shared registered multiplier: unsigned coefficient times signed difference.
module rfp_mul #(
  parameter int AW = 24,
  parameter int BW = 30
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= $signed({1'b0, a}) * b;
    end
  end

endmodule

@@ sv/resonant_four_pole_filter.sv @@
// Resonant four-pole filter top level: sequencer, stages and output modes.
//
//   channel   dir   fields (lowest bit up)          handshake
//   s_        in    tdata: sample_in                s_tvalid / s_tready
//   m_        out   tdata: sample_out               m_tvalid / m_tready
//   cfg_      in    cfg_index, cfg_data             cfg_valid / cfg_ready
//
// Each sample runs five products (feedback and four poles) through the one
// shared multiplier, each as a difference, a multiply and an accumulate with
// clamp, and then loads the output register. s_tready is high only while the
// sequencer is idle. A stalled result holds the sequencer at its last step;
// cfg_ready is always high. Synchronous reset clears the stages, registers
// and handshake state.
module resonant_four_pole_filter
  import rfp_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // sample_in
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,   // sample_out
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_index_t          cfg_index,
  input  logic [COEF_FRAC_BITS + 7:0] cfg_data
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int F       = COEF_FRAC_BITS;
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int STW     = SW + 4;
  localparam int CW      = F;
  localparam int GW      = F + 8;
  localparam int DW      = STW + 2;
  localparam int PW      = GW + DW + 1;
  localparam int SHW     = PW - F;
  localparam int AW      = SHW + 1;
  localparam int YW      = STW + 1;

  localparam logic signed [AW-1:0] ST_MAX  = AW'({1'b0, {(STW-1){1'b1}}});
  localparam logic signed [AW-1:0] ST_MIN  = ~ST_MAX;
  localparam logic signed [YW-1:0] OUT_MAX = YW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [YW-1:0] OUT_MIN = ~OUT_MAX;

  localparam logic [2:0] OP_FB = 3'd0;
  localparam logic [2:0] OP_P1 = 3'd1;
  localparam logic [2:0] OP_P2 = 3'd2;
  localparam logic [2:0] OP_P3 = 3'd3;
  localparam logic [2:0] OP_P4 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  state_t                  state;
  logic [2:0]              op;
  logic signed [SW-1:0]    x;
  logic signed [STW-1:0]   fb;
  logic signed [STW-1:0]   s1, s2, s3, s4;
  logic signed [DW-1:0]    diff;
  logic [SW-1:0]           out_data;

  logic [CW-1:0]           cutoff;
  logic [GW-1:0]           gain;
  mode_t                   mode;

  logic signed [DW-1:0]    diff_next;
  logic [GW-1:0]           mul_a;
  logic signed [PW-1:0]    prod;
  logic signed [SHW-1:0]   shifted;
  logic signed [STW-1:0]   acc_sel;
  logic signed [AW-1:0]    acc_sum;
  logic signed [STW-1:0]   st_new;
  logic signed [YW-1:0]    y_sel;
  logic [SW-1:0]           y_sat;

  rfp_cfg #(
    .CW (CW),
    .GW (GW)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cutoff    (cutoff),
    .gain      (gain),
    .mode      (mode)
  );

  rfp_mul #(
    .AW (GW),
    .BW (DW)
  ) u_mul (
    .clk  (clk),
    .en   (state == ST_MUL),
    .a    (mul_a),
    .b    (diff),
    .prod (prod)
  );

  // target minus accumulator for the current pole step, s1 minus s2 for feedback
  always_comb begin
    case (op)
      OP_FB:   diff_next = DW'(s1) - DW'(s2);
      OP_P1:   diff_next = DW'(x) + DW'(fb) - DW'(s1);
      OP_P2:   diff_next = DW'(s1) - DW'(s2);
      OP_P3:   diff_next = DW'(s2) - DW'(s3);
      OP_P4:   diff_next = DW'(s3) - DW'(s4);
      default: diff_next = '0;
    endcase
  end

  assign mul_a   = (op == OP_FB) ? gain : GW'(cutoff);
  assign shifted = $signed(prod[PW-1:F]);

  // feedback adds to zero, so the same clamp saturates it
  always_comb begin
    case (op)
      OP_P1:   acc_sel = s1;
      OP_P2:   acc_sel = s2;
      OP_P3:   acc_sel = s3;
      OP_P4:   acc_sel = s4;
      default: acc_sel = '0;
    endcase
  end

  assign acc_sum = AW'(acc_sel) + AW'(shifted);

  always_comb begin
    if (acc_sum > ST_MAX) begin
      st_new = ST_MAX[STW-1:0];
    end else if (acc_sum < ST_MIN) begin
      st_new = ST_MIN[STW-1:0];
    end else begin
      st_new = acc_sum[STW-1:0];
    end
  end

  always_comb begin
    case (mode)
      MODE_LOWPASS:  y_sel = YW'(s4);
      MODE_HIGHPASS: y_sel = YW'(x) - YW'(s4);
      MODE_BANDPASS: y_sel = YW'(s1) - YW'(s4);
      default:       y_sel = '0;
    endcase
  end

  always_comb begin
    if (y_sel > OUT_MAX) begin
      y_sat = OUT_MAX[SW-1:0];
    end else if (y_sel < OUT_MIN) begin
      y_sat = OUT_MIN[SW-1:0];
    end else begin
      y_sat = y_sel[SW-1:0];
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = TDATA_W'(out_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_FB;
      m_tvalid <= 1'b0;
      s1       <= '0;
      s2       <= '0;
      s3       <= '0;
      s4       <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x     <= s_tdata[SW-1:0];
            op    <= OP_FB;
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          diff  <= diff_next;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          case (op)
            OP_FB:   fb <= st_new;
            OP_P1:   s1 <= st_new;
            OP_P2:   s2 <= st_new;
            OP_P3:   s3 <= st_new;
            OP_P4:   s4 <= st_new;
            default: fb <= st_new;
          endcase
          if (op == OP_P4) begin
            state <= ST_OUT;
          end else begin
            op    <= op + 3'd1;
            state <= ST_DIFF;
          end
        end
        ST_OUT: begin
          // hold until the previous result is taken
          if (!m_tvalid || m_tready) begin
            out_data <= y_sat;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/rfp_checker.sv @@
// Port-level assertion checker for the filter, bound to the top level.
`include "resonant_four_pole_filter_assert.svh"

module rfp_checker #(
  parameter int TDATA_W = 24
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  // a stalled result keeps its value
  `RFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // an accepted request makes the block busy
  `RFP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !$rose(m_tvalid))

  // a result appears only at the end of a busy period
  `RFP_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready))

endmodule

bind resonant_four_pole_filter rfp_checker #(
  .TDATA_W (TDATA_W)
) u_rfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb_resonant_four_pole_filter.sv @@
// Self-checking testbench for the resonant four-pole filter with a built-in predictor.
`timescale 1ns / 100ps

module tb_resonant_four_pole_filter
  import rfp_pkg::*;
;

  localparam int SAMPLE_W    = 24;
  localparam int STAGE_W     = SAMPLE_W + 4;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int DRAIN_TICKS = 20;
  localparam int PRINT_CAP   = 100;
  localparam logic [15:0] CUTOFF_099 = 16'd64880;
  localparam cfg_index_t REG_SPARE = REG_MODE + 8'd1;
  localparam cfg_index_t REG_TOP   = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;    // sample_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;         // sample_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // filter settings and stage values as the predictor sees them
  logic [15:0] cutoff_q;
  logic [23:0] gain_q;
  mode_t       mode_q;
  longint      stage_q[4];

  logic [SAMPLE_W-1:0] expected_out[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  resonant_four_pole_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_signed(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint pole_step(longint acc, longint target);
    longint p;
    p = longint'(cutoff_q) * (target - acc);
    return clamp_signed(acc + (p >>> FRAC_BITS), STAGE_W);
  endfunction

  function automatic logic [SAMPLE_W-1:0] filter_sample(logic [SAMPLE_W-1:0] raw);
    longint x;
    longint fb;
    longint y;
    x = longint'($signed(raw));
    fb = clamp_signed((longint'(gain_q) * (stage_q[0] - stage_q[1])) >>> FRAC_BITS, STAGE_W);
    stage_q[0] = pole_step(stage_q[0], x + fb);
    stage_q[1] = pole_step(stage_q[1], stage_q[0]);
    stage_q[2] = pole_step(stage_q[2], stage_q[1]);
    stage_q[3] = pole_step(stage_q[3], stage_q[2]);
    case (mode_q)
      MODE_LOWPASS:  y = stage_q[3];
      MODE_HIGHPASS: y = x - stage_q[3];
      MODE_BANDPASS: y = stage_q[0] - stage_q[3];
      default:       y = 0;
    endcase
    y = clamp_signed(y, SAMPLE_W);
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                 logic [SAMPLE_W-1:0] want);
    if (error_count < PRINT_CAP)
      $display("[tb] %0t mismatch, %s: got %0d want %0d", $time, what,
               $signed(got), $signed(want));
    error_count++;
  endtask

  // receiver side: stall at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every accepted result with the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("result with no request pending", m_tdata, '0);
      end else begin
        if (m_tdata !== expected_out[0])
          report_mismatch("sample_out", m_tdata, expected_out[0]);
        void'(expected_out.pop_front());
      end
    end
  end

  // leave cfg_valid high; end_writes drops it
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CUTOFF: cutoff_q = value[15:0];
      REG_GAIN:   gain_q   = value[23:0];
      REG_MODE:   mode_q   = mode_t'(value[1:0]);
      default:    ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] cutoff, logic [23:0] gain, mode_t mode);
    write_reg(REG_CUTOFF, CFG_DATA_W'(cutoff));
    write_reg(REG_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    end_writes();
  endtask

  // leave s_tvalid high so back-to-back requests need no extra edge
  task automatic send_sample(logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    expected_out.push_back(filter_sample(sample));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  task automatic test_defaults_after_reset();
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000001);
  endtask

  task automatic test_output_modes();
    mode_t m;
    m = m.first();
    for (int i = 0; i < m.num(); i++) begin
      wait_idle();
      configure(16'h8000, 24'h008000, m);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'hFFFFFF);
      m = m.next();
    end
  endtask

  // full cutoff and gain: drive stages and output into both clamps
  task automatic test_saturation();
    wait_idle();
    configure(16'hFFFF, 24'hFFFFFF, MODE_HIGHPASS);
    for (int i = 0; i < 6; i++)
      send_sample(i[0] ? 24'h800000 : 24'h7FFFFF);
  endtask

  // upper data bits must be dropped, unused indexes ignored
  task automatic test_register_writes();
    wait_idle();
    write_reg(REG_CUTOFF, 24'hA5_4000);
    write_reg(REG_MODE, 24'hFFFFFC | CFG_DATA_W'(MODE_BANDPASS));
    write_reg(REG_GAIN, 24'h02_0000);
    write_reg(REG_SPARE, 24'hFFFFFF);
    write_reg(REG_TOP, 24'h123456);
    end_writes();
    send_sample(24'h400000);
    send_sample(24'hC00000);
    send_sample(24'h000000);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    logic [15:0] cutoff;
    logic [23:0] gain;
    logic [SAMPLE_W-1:0] sample;
    int amp;
    int half_period;
    for (int ph = 0; ph < phases; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case ($urandom_range(7))
        0: cutoff = 16'hFFFF;
        1: cutoff = 16'h0000;
        2: cutoff = 16'($urandom_range(1, 512));
        default: cutoff = 16'($urandom_range(CUTOFF_099));
      endcase
      case ($urandom_range(7))
        0: gain = 24'hFFFFFF;
        1: gain = 24'h000000;
        2: gain = 24'($urandom);
        default: gain = 24'($urandom_range(4 << FRAC_BITS));
      endcase
      if (ph == 0) begin
        cutoff = 16'hFFFF;
        gain = 24'hFFFFFF;
      end else if (ph == 1) begin
        cutoff = 16'h0000;
        gain = 24'h000000;
      end
      // random order of writes, with junk in the upper data bits now and then
      if ($urandom_range(1)) begin
        write_reg(REG_MODE, 24'($urandom) & 24'hFFFFFC | 24'($urandom_range(3)));
        write_reg(REG_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_CUTOFF, 24'($urandom) & 24'hFF0000 | CFG_DATA_W'(cutoff));
      end else begin
        configure(cutoff, gain, mode_t'($urandom_range(3)));
      end
      end_writes();
      amp = $urandom_range(8388607);
      half_period = $urandom_range(1, 40);
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(9))
          0: sample = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
          1, 2, 3: sample = 24'($urandom);
          default: begin
            sample = ((n / half_period) % 2) ? 24'(amp) : 24'(-amp);
            sample = sample + 24'($signed($urandom_range(512)) - 256);
          end
        endcase
        send_sample(sample);
      end
    end
  endtask

  initial begin
    cutoff_q = '0;
    gain_q = '0;
    mode_q = MODE_LOWPASS;
    foreach (stage_q[i]) stage_q[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults_after_reset();
    test_output_modes();
    test_saturation();
    test_register_writes();
    test_random_phases(13, 100);
    wait_idle();
    if (error_count == 0 && expected_out.size() == 0) begin
      $display("[resonant_four_pole_filter] OK");
    end else begin
      $display("[resonant_four_pole_filter] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[resonant_four_pole_filter] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/rfp_pkg.sv
sv/rfp_cfg.sv
sv/rfp_mul.sv
sv/resonant_four_pole_filter.sv
sv/rfp_checker.sv
tb/tb_resonant_four_pole_filter.sv
